@@ src/double_ended_queue_defines.svh @@
// Assertion macros shared by the double-ended queue checker.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/deq_pkg.sv @@
// Shared constants for the double-ended queue: default sizes, request
// opcodes and status codes. No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ src/deq_req_if.sv @@
// Request channel of the double-ended queue: opcode and push word.
// Depends on deq_pkg.
`default_nettype none

interface deq_req_if #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH
) ();
    logic                      valid;
    logic                      ready;
    logic [deq_pkg::OP_W-1:0]  op;
    logic [DATA_WIDTH-1:0]     data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

`default_nettype wire

@@ src/deq_rsp_if.sv @@
// Result channel of the double-ended queue: popped word, status, count and peeks.
// Depends on deq_pkg.
`default_nettype none

interface deq_rsp_if #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH,
    parameter int CNT_W      = $clog2(deq_pkg::DEPTH + 1)
) ();
    logic                          valid;
    logic                          ready;
    logic [DATA_WIDTH-1:0]         popped_data;
    logic                          popped_valid;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [CNT_W-1:0]              count_after;
    logic [DATA_WIDTH-1:0]         head_peek;
    logic [DATA_WIDTH-1:0]         tail_peek;

    modport source (output valid, output popped_data, output popped_valid, output status,
                    output count_after, output head_peek, output tail_peek, input ready);
    modport sink   (input valid, input popped_data, input popped_valid, input status,
                    input count_after, input head_peek, input tail_peek, output ready);
endinterface

`default_nettype wire

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue on a ring memory with cached head and tail words.
// Depends on deq_pkg, deq_req_if and deq_rsp_if.
//
//   channel | dir | contents
//   req     | in  | op, data_in
//   rsp     | out | popped_data, popped_valid, status, count_after, head_peek, tail_peek
//
// Push, none and refused requests register their result straight from idle; a pop
// that leaves words first passes through the read state, because the new head or
// tail word comes from the memory's registered read port.
// Reset clears pointers, count, sequencer and result valid; the memory needs no clearing.
// A waiting result does not block the next request while it is being taken.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } deq_state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    // Ring memory.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= req.data_in;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Control state.
    deq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             read_head_reg, read_head_next;

    // Cached words at the two ends; valid when count is nonzero outside the read state.
    logic [DATA_WIDTH-1:0] head_word_reg, head_word_next;
    logic [DATA_WIDTH-1:0] tail_word_reg, tail_word_next;

    // Result register.
    logic [DATA_WIDTH-1:0]        popped_data_reg, popped_data_next;
    logic                         popped_valid_reg, popped_valid_next;
    logic [deq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]             count_after_reg, count_after_next;
    logic [DATA_WIDTH-1:0]        head_peek_reg, head_peek_next;
    logic [DATA_WIDTH-1:0]        tail_peek_reg, tail_peek_next;

    logic accept;
    logic need_read;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        read_head_next    = read_head_reg;
        head_word_next    = head_word_reg;
        tail_word_next    = tail_word_reg;
        popped_data_next  = popped_data_reg;
        popped_valid_next = popped_valid_reg;
        status_next       = status_reg;
        count_after_next  = count_after_reg;
        head_peek_next    = head_peek_reg;
        tail_peek_next    = tail_peek_reg;
        mem_we            = 1'b0;
        mem_waddr         = tail_reg;
        mem_raddr         = idx_inc(head_reg);
        need_read         = 1'b0;
        out_valid_next    = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    popped_data_next  = '0;
                    popped_valid_next = 1'b0;
                    status_next       = deq_pkg::STATUS_OK;
                    unique case (req.op)
                        deq_pkg::OP_PUSH_HEAD:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = idx_dec(head_reg);
                                head_next      = idx_dec(head_reg);
                                count_next     = count_reg + 1'b1;
                                head_word_next = req.data_in;
                                if (count_reg == '0)
                                begin
                                    tail_word_next = req.data_in;
                                end
                            end
                        end
                        deq_pkg::OP_PUSH_TAIL:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = tail_reg;
                                tail_next      = idx_inc(tail_reg);
                                count_next     = count_reg + 1'b1;
                                tail_word_next = req.data_in;
                                if (count_reg == '0)
                                begin
                                    head_word_next = req.data_in;
                                end
                            end
                        end
                        deq_pkg::OP_POP_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_data_next  = head_word_reg;
                                popped_valid_next = 1'b1;
                                head_next         = idx_inc(head_reg);
                                count_next        = count_reg - 1'b1;
                                mem_raddr         = idx_inc(head_reg);
                                read_head_next    = 1'b1;
                                need_read         = (count_reg != CNT_W'(1));
                            end
                        end
                        deq_pkg::OP_POP_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_data_next  = tail_word_reg;
                                popped_valid_next = 1'b1;
                                tail_next         = idx_dec(tail_reg);
                                count_next        = count_reg - 1'b1;
                                // The new last word sits one below the new tail pointer.
                                mem_raddr         = idx_dec(idx_dec(tail_reg));
                                read_head_next    = 1'b0;
                                need_read         = (count_reg != CNT_W'(1));
                            end
                        end
                        default:
                        begin
                            // Unused codes act as a plain status read.
                        end
                    endcase
                    count_after_next = count_next;
                    head_peek_next   = (count_next == '0) ? '0 : head_word_next;
                    tail_peek_next   = (count_next == '0) ? '0 : tail_word_next;
                    if (need_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (read_head_reg)
                begin
                    head_word_next = rdata_reg;
                end
                else
                begin
                    tail_word_next = rdata_reg;
                end
                head_peek_next = head_word_next;
                tail_peek_next = tail_word_next;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            read_head_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            read_head_reg <= read_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_word_reg    <= head_word_next;
        tail_word_reg    <= tail_word_next;
        popped_data_reg  <= popped_data_next;
        popped_valid_reg <= popped_valid_next;
        status_reg       <= status_next;
        count_after_reg  <= count_after_next;
        head_peek_reg    <= head_peek_next;
        tail_peek_reg    <= tail_peek_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_data  = popped_data_reg;
    assign rsp.popped_valid = popped_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.count_after  = count_after_reg;
    assign rsp.head_peek    = head_peek_reg;
    assign rsp.tail_peek    = tail_peek_reg;

endmodule

`default_nettype wire

@@ src/deq_checker.sv @@
// Port-level checks on the double-ended queue result channel, bound to the top level.
// Depends on deq_pkg and double_ended_queue_defines.svh.
`default_nettype none
`include "double_ended_queue_defines.svh"

module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [DATA_WIDTH-1:0]                rsp_popped_data,
    input wire logic                                 rsp_popped_valid,
    input wire logic [deq_pkg::STATUS_W-1:0]         rsp_status,
    input wire logic [$clog2(DEPTH + 1)-1:0]         rsp_count_after,
    input wire logic [DATA_WIDTH-1:0]                rsp_head_peek,
    input wire logic [DATA_WIDTH-1:0]                rsp_tail_peek
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // A word only comes out of a request that succeeded.
    `DEQ_ASSERT_IMPL(a_pop_ok, rsp_valid && rsp_popped_valid, rsp_status == deq_pkg::STATUS_OK, "popped word with error status")

    `DEQ_ASSERT_IMPL(a_no_pop_zero, rsp_valid && !rsp_popped_valid, rsp_popped_data == '0, "nonzero data without a pop")

    `DEQ_ASSERT_IMPL(a_empty_peeks, rsp_valid && (rsp_count_after == '0), (rsp_head_peek == '0) && (rsp_tail_peek == '0), "peeks nonzero on empty queue")

    // A refused request leaves the queue at the bound that caused it.
    `DEQ_ASSERT_IMPL(a_refusal_count, rsp_valid && (rsp_status != deq_pkg::STATUS_OK), ((rsp_status == deq_pkg::STATUS_EMPTY) && (rsp_count_after == '0)) || ((rsp_status == deq_pkg::STATUS_FULL) && (rsp_count_after == CNT_FULL)), "refusal status does not match count")

    `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count_after) && $stable(rsp_popped_data), "stalled result changed")

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_popped_data  (rsp.popped_data),
    .rsp_popped_valid (rsp.popped_valid),
    .rsp_status       (rsp.status),
    .rsp_count_after  (rsp.count_after),
    .rsp_head_peek    (rsp.head_peek),
    .rsp_tail_peek    (rsp.tail_peek)
);

`default_nettype wire
